@@ src/assoc_cache_tag_directory_defines.svh @@
// Assertion macros for the associative cache tag directory.
// No dependencies; included by modules that carry concurrent checks.
`ifndef ASSOC_CACHE_TAG_DIRECTORY_DEFINES_SVH
`define ASSOC_CACHE_TAG_DIRECTORY_DEFINES_SVH

`ifndef ASSERT_OFF
`define ACTR_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ACTR_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) pre |=> post) else $error(msg);
`else
`define ACTR_ASSERT(label, clk, rst_n, prop, msg)
`define ACTR_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif

`endif

@@ src/actr_pkg.sv @@
// Shared types and codes for the associative cache tag directory.
// No dependencies.
`timescale 1ns / 1ps

package actr_pkg;

    localparam int OUTCOME_W = 2;
    localparam int WAY_W     = 2;

    typedef enum logic [1:0] {
        ST_INVALID = 2'd0,
        ST_VALID   = 2'd1,
        ST_PENDING = 2'd2
    } entry_state_t;

    typedef enum logic [OUTCOME_W-1:0] {
        OUT_MISS = 2'd0,
        OUT_HIT  = 2'd1,
        OUT_WAIT = 2'd2,
        OUT_FILL = 2'd3
    } outcome_t;

    typedef struct packed {
        logic hit;
        logic pend;
        logic free;
    } match_t;

endpackage

@@ src/actr_entry_cmp.sv @@
// Shared tag comparator: checks one directory entry against the search tag.
// Depends on actr_pkg.
`timescale 1ns / 1ps

module actr_entry_cmp #(
    parameter int TAG_WIDTH = 12
) (
    input  logic [TAG_WIDTH-1:0]  key,
    input  logic [TAG_WIDTH-1:0]  entry_tag,
    input  actr_pkg::entry_state_t entry_state,
    output actr_pkg::match_t      flags
);

    logic tag_eq;

    assign tag_eq     = (entry_tag == key);
    assign flags.hit  = tag_eq && (entry_state == actr_pkg::ST_VALID);
    assign flags.pend = tag_eq && (entry_state == actr_pkg::ST_PENDING);
    assign flags.free = (entry_state == actr_pkg::ST_INVALID);

endmodule

@@ src/assoc_cache_tag_directory.sv @@
// Top level of the fully associative cache tag directory: sequencer, entry
// states and tag memory. Depends on actr_pkg, actr_entry_cmp and the defines header.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------------
//  req     | in        | req_valid/req_stall  | operation, tag
//  rsp     | out       | rsp_valid/rsp_stall  | outcome, way, filled_any
//
// One comparator walks the entries, one tag memory read per cycle while the scan advances.
// A lookup stops at the first entry that hits or waits; a miss or a fill scans every entry.
// Reset marks all entries invalid at once; no clearing pass.
// A new item is taken while a result waits; the scan holds on its last step
// until the result register is free.
`timescale 1ns / 1ps
`include "assoc_cache_tag_directory_defines.svh"

module assoc_cache_tag_directory #(
    parameter int NUM_WAYS  = 4,
    parameter int TAG_WIDTH = 12
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    output logic                           req_stall,
    input  logic                           operation,
    input  logic [TAG_WIDTH-1:0]           tag,
    output logic                           rsp_valid,
    input  logic                           rsp_stall,
    output logic [actr_pkg::OUTCOME_W-1:0] outcome,
    output logic [actr_pkg::WAY_W-1:0]     way,
    output logic                           filled_any
);

    localparam int IDX_W = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_WAYS - 1);

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } seq_state_t;

    seq_state_t                        state_reg;
    logic                              op_reg;
    logic [TAG_WIDTH-1:0]              key_reg;
    logic [IDX_W-1:0]                  cmp_idx_reg;
    logic [TAG_WIDTH-1:0]              tag_rd_reg;
    logic                              free_found_reg;
    logic [IDX_W-1:0]                  free_idx_reg;
    logic                              any_reg;
    actr_pkg::entry_state_t            entry_state_reg [NUM_WAYS];
    logic [TAG_WIDTH-1:0]              tag_mem [NUM_WAYS];

    logic                              rsp_valid_reg;
    actr_pkg::outcome_t                outcome_reg;
    logic [actr_pkg::WAY_W-1:0]        way_reg;
    logic                              filled_any_reg;

    actr_pkg::outcome_t                outcome_next;
    logic [actr_pkg::WAY_W-1:0]        way_next;
    logic                              filled_any_next;

    actr_pkg::entry_state_t            cur_state;
    actr_pkg::match_t                  cmp_flags;
    logic                              accept;
    logic                              out_free;
    logic                              is_last;
    logic                              lookup_found;
    logic                              finish;
    logic                              advance;
    logic                              do_alloc;
    logic                              fill_set;
    logic [IDX_W-1:0]                  alloc_idx;
    logic [IDX_W-1:0]                  rd_addr;
    logic [IDX_W-1:0]                  way_idx;
    logic [IDX_W+1:0]                  way_wide;

    assign cur_state = entry_state_reg[cmp_idx_reg];

    actr_entry_cmp #(
        .TAG_WIDTH(TAG_WIDTH)
    ) u_cmp (
        .key        (key_reg),
        .entry_tag  (tag_rd_reg),
        .entry_state(cur_state),
        .flags      (cmp_flags)
    );

    assign req_stall    = (state_reg != S_IDLE);
    assign accept       = req_valid && !req_stall;
    assign out_free     = !rsp_valid_reg || !rsp_stall;
    assign is_last      = (cmp_idx_reg == LAST_IDX);
    assign lookup_found = !op_reg && (cmp_flags.hit || cmp_flags.pend);
    assign finish       = (state_reg == S_SCAN) && out_free && (is_last || lookup_found);
    assign advance      = (state_reg == S_SCAN) && !is_last && !lookup_found;
    assign do_alloc     = finish && !op_reg && !lookup_found;
    assign fill_set     = (state_reg == S_SCAN) && op_reg && cmp_flags.pend;
    assign rd_addr      = accept ? '0 : cmp_idx_reg + 1'b1;

    always_comb
    begin
        if (free_found_reg)
            alloc_idx = free_idx_reg;
        else if (cmp_flags.free)
            alloc_idx = cmp_idx_reg;
        else
            alloc_idx = '0;
    end

    always_comb
    begin
        way_idx         = '0;
        filled_any_next = 1'b0;
        priority if (op_reg)
        begin
            outcome_next    = actr_pkg::OUT_FILL;
            filled_any_next = any_reg || cmp_flags.pend;
        end
        else if (cmp_flags.hit)
        begin
            outcome_next = actr_pkg::OUT_HIT;
            way_idx      = cmp_idx_reg;
        end
        else if (cmp_flags.pend)
        begin
            outcome_next = actr_pkg::OUT_WAIT;
            way_idx      = cmp_idx_reg;
        end
        else
        begin
            outcome_next = actr_pkg::OUT_MISS;
            way_idx      = alloc_idx;
        end
        way_wide = {2'b00, way_idx};
        way_next = way_wide[actr_pkg::WAY_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            op_reg         <= 1'b0;
            key_reg        <= '0;
            cmp_idx_reg    <= '0;
            free_found_reg <= 1'b0;
            free_idx_reg   <= '0;
            any_reg        <= 1'b0;
            rsp_valid_reg  <= 1'b0;
            outcome_reg    <= actr_pkg::OUT_MISS;
            way_reg        <= '0;
            filled_any_reg <= 1'b0;
            for (int i = 0; i < NUM_WAYS; i++)
                entry_state_reg[i] <= actr_pkg::ST_INVALID;
        end
        else
        begin
            if (rsp_valid_reg && !rsp_stall)
                rsp_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg      <= S_SCAN;
                        op_reg         <= operation;
                        key_reg        <= tag;
                        cmp_idx_reg    <= '0;
                        free_found_reg <= 1'b0;
                        any_reg        <= 1'b0;
                    end
                end
                S_SCAN:
                begin
                    if (fill_set)
                    begin
                        entry_state_reg[cmp_idx_reg] <= actr_pkg::ST_VALID;
                        any_reg                      <= 1'b1;
                    end
                    if (do_alloc)
                        entry_state_reg[alloc_idx] <= actr_pkg::ST_PENDING;
                    if (finish)
                    begin
                        state_reg      <= S_IDLE;
                        rsp_valid_reg  <= 1'b1;
                        outcome_reg    <= outcome_next;
                        way_reg        <= way_next;
                        filled_any_reg <= filled_any_next;
                    end
                    else if (advance)
                    begin
                        cmp_idx_reg <= cmp_idx_reg + 1'b1;
                        if (!free_found_reg && cmp_flags.free)
                        begin
                            free_found_reg <= 1'b1;
                            free_idx_reg   <= cmp_idx_reg;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // tag memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (do_alloc)
            tag_mem[alloc_idx] <= key_reg;
        if (accept || advance)
            tag_rd_reg <= tag_mem[rd_addr];
    end

    assign rsp_valid  = rsp_valid_reg;
    assign outcome    = outcome_reg;
    assign way        = way_reg;
    assign filled_any = filled_any_reg;

    `ACTR_ASSERT_NEXT(a_accept_starts_scan, clk, rst_n, accept, (state_reg == S_SCAN) && (cmp_idx_reg == '0), "accepted item did not start scan at entry 0")
    `ACTR_ASSERT_NEXT(a_alloc_pending, clk, rst_n, do_alloc, entry_state_reg[$past(alloc_idx)] == actr_pkg::ST_PENDING, "allocated entry not pending")
    `ACTR_ASSERT(a_fill_way_zero, clk, rst_n, (rsp_valid_reg && (outcome_reg == actr_pkg::OUT_FILL)) |-> (way_reg == '0), "fill result with nonzero way")
    `ACTR_ASSERT(a_lookup_no_fill_flag, clk, rst_n, (rsp_valid_reg && (outcome_reg != actr_pkg::OUT_FILL)) |-> !filled_any_reg, "lookup result with filled_any set")
    `ACTR_ASSERT(a_idx_in_range, clk, rst_n, (state_reg == S_SCAN) |-> (cmp_idx_reg <= LAST_IDX), "scan index past last entry")

endmodule

@@ tb/tag_dir_monitor.sv @@
// Watches both channels of the cache tag directory, keeps a shadow copy of
// its entries and checks every result against the predicted one.
// Depends on actr_pkg.
`timescale 1ns / 1ps

module tag_dir_monitor #(
    parameter int NUM_WAYS  = 4,
    parameter int TAG_WIDTH = 12
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    input  logic                           req_stall,
    input  logic                           operation,
    input  logic [TAG_WIDTH-1:0]           tag,
    input  logic                           rsp_valid,
    input  logic                           rsp_stall,
    input  logic [actr_pkg::OUTCOME_W-1:0] outcome,
    input  logic [actr_pkg::WAY_W-1:0]     way,
    input  logic                           filled_any,
    output int                             errors,
    output int                             awaiting
);

    typedef struct packed {
        actr_pkg::outcome_t           oc;
        logic [actr_pkg::WAY_W-1:0]   w;
        logic                         any;
    } dir_rsp_t;

    logic [TAG_WIDTH-1:0]   shadow_tag [NUM_WAYS];
    actr_pkg::entry_state_t shadow_st  [NUM_WAYS];
    dir_rsp_t               rsp_fifo   [$];

    function automatic dir_rsp_t resolve_access(input logic is_fill,
                                                input logic [TAG_WIDTH-1:0] t);
        dir_rsp_t r;
        int       victim;
        logic     found;
        r.oc  = actr_pkg::OUT_FILL;
        r.w   = '0;
        r.any = 1'b0;
        if (is_fill)
        begin
            for (int i = 0; i < NUM_WAYS; i++)
            begin
                if (shadow_tag[i] == t && shadow_st[i] == actr_pkg::ST_PENDING)
                begin
                    shadow_st[i] = actr_pkg::ST_VALID;
                    r.any = 1'b1;
                end
            end
            return r;
        end
        found = 1'b0;
        for (int i = 0; i < NUM_WAYS; i++)
        begin
            if (!found && shadow_tag[i] == t && shadow_st[i] != actr_pkg::ST_INVALID)
            begin
                found = 1'b1;
                r.oc  = (shadow_st[i] == actr_pkg::ST_VALID) ? actr_pkg::OUT_HIT
                                                              : actr_pkg::OUT_WAIT;
                r.w   = actr_pkg::WAY_W'(i);
            end
        end
        if (!found)
        begin
            victim = 0;
            for (int i = NUM_WAYS - 1; i >= 0; i--)
            begin
                if (shadow_st[i] == actr_pkg::ST_INVALID)
                    victim = i;
            end
            shadow_tag[victim] = t;
            shadow_st[victim]  = actr_pkg::ST_PENDING;
            r.oc = actr_pkg::OUT_MISS;
            r.w  = actr_pkg::WAY_W'(victim);
        end
        return r;
    endfunction

    task automatic flag_error(input string msg);
        errors++;
        if (errors <= 10)
            $display("%0t: %s", $time, msg);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        dir_rsp_t exp_rsp;
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_WAYS; i++)
            begin
                shadow_tag[i] = '0;
                shadow_st[i]  = actr_pkg::ST_INVALID;
            end
            rsp_fifo.delete();
            errors   = 0;
            awaiting = 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (rsp_fifo.size() == 0)
                    flag_error($sformatf("unexpected result outcome=%0d way=%0d filled_any=%0b",
                                         outcome, way, filled_any));
                else
                begin
                    exp_rsp = rsp_fifo.pop_front();
                    if (outcome !== exp_rsp.oc || way !== exp_rsp.w
                        || filled_any !== exp_rsp.any)
                        flag_error($sformatf(
                            "mismatch: expected %0d %0d %0b, got %0d %0d %0b",
                            exp_rsp.oc, exp_rsp.w, exp_rsp.any, outcome, way, filled_any));
                end
            end
            if (req_valid && !req_stall)
                rsp_fifo.push_back(resolve_access(operation, tag));
            awaiting = rsp_fifo.size();
        end
    end

endmodule

@@ tb/tb.sv @@
// Top of the cache tag directory testbench: clock, reset, lookup/fill
// stimulus, response-side stalls and the verdict.
// Depends on actr_pkg, tag_dir_monitor and assoc_cache_tag_directory.
`timescale 1ns / 1ps

module tb;

    localparam int   NW          = 4;
    localparam int   TW          = 12;
    localparam int   ITEM_COUNT  = 950;
    localparam int   POOL_SIZE   = 6;
    localparam int   CYCLE_LIMIT = 400000;
    localparam logic OP_LOOKUP   = 1'b0;
    localparam logic OP_FILL     = 1'b1;
    localparam int   N_DIRECTED  = 17;

    logic                           clk;
    logic                           rst_n;
    logic                           req_valid;
    logic                           req_stall;
    logic                           operation;
    logic [TW-1:0]                  tag;
    logic                           rsp_valid;
    logic                           rsp_stall;
    logic [actr_pkg::OUTCOME_W-1:0] outcome;
    logic [actr_pkg::WAY_W-1:0]     way;
    logic                           filled_any;
    int                             errors;
    int                             awaiting;
    int                             items_sent = 0;
    int                             cycle_cnt = 0;
    logic [TW-1:0]                  tag_pool [POOL_SIZE];

    logic dir_op [N_DIRECTED] = '{OP_FILL, OP_LOOKUP, OP_LOOKUP, OP_FILL, OP_LOOKUP,
                                  OP_FILL, OP_LOOKUP, OP_LOOKUP, OP_LOOKUP, OP_LOOKUP,
                                  OP_LOOKUP, OP_FILL, OP_LOOKUP, OP_LOOKUP, OP_FILL,
                                  OP_FILL, OP_LOOKUP};
    logic [TW-1:0] dir_tag [N_DIRECTED] = '{12'h000, 12'h000, 12'h000, 12'h000, 12'h000,
                                            12'h000, 12'hfff, 12'h555, 12'haaa, 12'h123,
                                            12'h000, 12'hfff, 12'hfff, 12'haaa, 12'h123,
                                            12'haaa, 12'haaa};

    assoc_cache_tag_directory #(
        .NUM_WAYS  (NW),
        .TAG_WIDTH (TW)
    ) uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .operation  (operation),
        .tag        (tag),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .outcome    (outcome),
        .way        (way),
        .filled_any (filled_any)
    );

    tag_dir_monitor #(
        .NUM_WAYS  (NW),
        .TAG_WIDTH (TW)
    ) monitor (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .operation  (operation),
        .tag        (tag),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .outcome    (outcome),
        .way        (way),
        .filled_any (filled_any),
        .errors     (errors),
        .awaiting   (awaiting)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic offer(input logic op, input logic [TW-1:0] t);
        @(negedge clk);
        req_valid <= 1'b1;
        operation <= op;
        tag       <= t;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic idle(input int n);
        repeat (n)
        begin
            @(negedge clk);
            req_valid <= 1'b0;
        end
    endtask

    // mostly traffic on a small tag set so hits, waits and fills line up
    function automatic void next_item(output logic op, output logic [TW-1:0] t);
        if ($urandom_range(0, 99) < 8)
        begin
            op = 1'($urandom_range(0, 1));
            t  = TW'($urandom);
        end
        else
        begin
            op = ($urandom_range(0, 99) < 40) ? OP_FILL : OP_LOOKUP;
            t  = tag_pool[$urandom_range(0, POOL_SIZE - 1)];
        end
        if ($urandom_range(0, 31) == 0)
            tag_pool[$urandom_range(0, POOL_SIZE - 1)] = TW'($urandom);
    endfunction

    initial
    begin : rsp_side
        int seg;
        int mode;
        bit held_off;
        held_off  = 1'b0;
        rsp_stall = 1'b0;
        forever
        begin
            seg  = $urandom_range(4, 40);
            mode = $urandom_range(0, 3);
            if (!held_off && items_sent >= 300)
            begin
                held_off = 1'b1;
                mode     = 4;
                seg      = 120;
            end
            repeat (seg)
            begin
                @(negedge clk);
                unique case (mode)
                    0: rsp_stall <= 1'b0;
                    1: rsp_stall <= ($urandom_range(0, 3) == 0);
                    2: rsp_stall <= ($urandom_range(0, 3) != 0);
                    3: rsp_stall <= ~rsp_stall;
                    default: rsp_stall <= 1'b1;
                endcase
            end
        end
    end

    initial
    begin : stimulus
        logic          op;
        logic [TW-1:0] t;
        int            burst;
        rst_n     = 1'b0;
        req_valid = 1'b0;
        operation = OP_LOOKUP;
        tag       = '0;
        for (int i = 0; i < POOL_SIZE; i++)
            tag_pool[i] = TW'($urandom);
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        for (int i = 0; i < N_DIRECTED; i++)
            offer(dir_op[i], dir_tag[i]);

        while (items_sent < ITEM_COUNT)
        begin
            burst = $urandom_range(1, 30);
            repeat (burst)
            begin
                next_item(op, t);
                offer(op, t);
            end
            if ($urandom_range(0, 2) != 0)
                idle($urandom_range(1, 10));
        end
        idle(1);

        wait (awaiting == 0);
        repeat (20) @(posedge clk);
        if (errors == 0 && awaiting == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
